@@ rtl/dfbs_pkg.sv @@
// Shared types and constants of the delimited field byte selector.
// Holds the configuration, command and status structs and the register map.
// No dependencies.
`default_nettype none

package dfbs_pkg;

	// Default sizes, handed to the top level as parameter defaults
	localparam int DFBS_LINE_LIMIT        = 65534;
	localparam int DFBS_FIRST_FIELD_DEPTH = 63;
	localparam int DFBS_RANGE_SLOTS       = 6;

	// Fixed widths and limits
	localparam int POS_W       = 16;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int MAX_RANGES  = 6;
	localparam int MAX_RESULTS = 64;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_COUNT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PAIR_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PAIR_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PAIR_C = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OPTION_FLAGS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_DELIM  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_DELIM = 3'd7;

	// Option flag bits
	localparam int OPT_COMPLEMENT = 0;
	localparam int OPT_ONLY_DELIM = 1;
	localparam int OPT_ZERO_TERM  = 2;
	localparam int OPT_OUT_DELIM  = 3;

	// Reset value of the field delimiter (tab) and the terminator bytes
	localparam logic [7:0] FIELD_DELIM_RESET = 8'h09;
	localparam logic [7:0] NEWLINE_BYTE      = 8'h0A;
	localparam logic [7:0] ZERO_BYTE         = 8'h00;

	typedef struct packed {
		logic                       select_mode;
		logic [2:0]                 range_count;
		logic [2:0][CFG_DATA_W-1:0] range_pair;
		logic [3:0]                 option_flags;
		logic [7:0]                 field_delimiter;
		logic [7:0]                 output_delimiter;
	} cfg_t;

	// Source of the word loaded into the output register
	typedef enum logic [1:0] {
		SRC_REL,
		SRC_MID,
		SRC_TERM
	} src_t;

	typedef struct packed {
		logic take;
		logic load;
		logic advance;
		logic last;
		src_t src;
	} cmd_t;

	typedef struct packed {
		logic slot_free;
		logic plan_rel;
		logic plan_mid;
		logic plan_term;
		logic q_mid;
		logic q_term;
		logic rel_last;
	} stat_t;

endpackage

`default_nettype wire

@@ rtl/dfbs_cfg.sv @@
// Configuration register file of the delimited field byte selector.
// Decodes the plain write port into the cfg_t struct; uses dfbs_pkg.
`default_nettype none

module dfbs_cfg
	import dfbs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// Write the addressed register, keep only its defined bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.select_mode      <= 1'b0;
			cfg_q.range_count      <= 3'd0;
			cfg_q.range_pair       <= '0;
			cfg_q.option_flags     <= 4'd0;
			cfg_q.field_delimiter  <= FIELD_DELIM_RESET;
			cfg_q.output_delimiter <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SELECT_MODE:  cfg_q.select_mode      <= cfg_data[0];
				CFG_RANGE_COUNT:  cfg_q.range_count      <= cfg_data[2:0];
				CFG_RANGE_PAIR_A: cfg_q.range_pair[0]    <= cfg_data;
				CFG_RANGE_PAIR_B: cfg_q.range_pair[1]    <= cfg_data;
				CFG_RANGE_PAIR_C: cfg_q.range_pair[2]    <= cfg_data;
				CFG_OPTION_FLAGS: cfg_q.option_flags     <= cfg_data[3:0];
				CFG_FIELD_DELIM:  cfg_q.field_delimiter  <= cfg_data[7:0];
				CFG_OUTPUT_DELIM: cfg_q.output_delimiter <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/dfbs_ctrl.sv @@
// Controller of the delimited field byte selector: sequences the words of one
// input byte (released first field, middle word, terminator). Uses dfbs_pkg.
`default_nettype none

module dfbs_ctrl
	import dfbs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  stat_t     stat,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_REL,
		ST_MID,
		ST_TERM
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Decide the next step and the command for the datapath
	always_comb begin
		cmd       = '0;
		cmd.src   = SRC_REL;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (stat.plan_rel) begin
						state_nxt = ST_PREP;
					end else if (stat.plan_mid) begin
						if (stat.slot_free) begin
							cmd.load  = 1'b1;
							cmd.src   = SRC_MID;
							cmd.last  = !stat.plan_term;
							state_nxt = stat.plan_term ? ST_TERM : ST_IDLE;
						end else begin
							state_nxt = ST_MID;
						end
					end else if (stat.plan_term) begin
						if (stat.slot_free) begin
							cmd.load = 1'b1;
							cmd.src  = SRC_TERM;
							cmd.last = 1'b1;
						end else begin
							state_nxt = ST_TERM;
						end
					end
				end
			end
			ST_PREP: begin
				// first stored byte is being read
				state_nxt = ST_REL;
			end
			ST_REL: begin
				if (stat.slot_free) begin
					cmd.load    = 1'b1;
					cmd.advance = 1'b1;
					cmd.src     = SRC_REL;
					cmd.last    = stat.rel_last && !stat.q_mid && !stat.q_term;
					if (stat.rel_last) begin
						if (stat.q_mid) begin
							state_nxt = ST_MID;
						end else if (stat.q_term) begin
							state_nxt = ST_TERM;
						end else begin
							state_nxt = ST_IDLE;
						end
					end
				end
			end
			ST_MID: begin
				if (stat.slot_free) begin
					cmd.load  = 1'b1;
					cmd.src   = SRC_MID;
					cmd.last  = !stat.q_term;
					state_nxt = stat.q_term ? ST_TERM : ST_IDLE;
				end
			end
			ST_TERM: begin
				if (stat.slot_free) begin
					cmd.load  = 1'b1;
					cmd.src   = SRC_TERM;
					cmd.last  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/dfbs_dp.sv @@
// Datapath of the delimited field byte selector: line state, range compare,
// first-field store, word plan and output register. Uses dfbs_pkg.
`default_nettype none

module dfbs_dp
	import dfbs_pkg::*;
#(
	parameter int LINE_LIMIT        = DFBS_LINE_LIMIT,
	parameter int FIRST_FIELD_DEPTH = DFBS_FIRST_FIELD_DEPTH,
	parameter int RANGE_SLOTS       = DFBS_RANGE_SLOTS
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cfg_t            cfg,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	input  cmd_t            cmd,
	output stat_t           stat,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	localparam int LW = $clog2(FIRST_FIELD_DEPTH + 1);
	localparam int AW = (FIRST_FIELD_DEPTH > 1) ? $clog2(FIRST_FIELD_DEPTH) : 1;

	// True when pos lies in one of the active ranges, inverted under complement
	function automatic logic range_select(input cfg_t c, input logic [2:0] cnt,
			input logic [POS_W-1:0] pos);
		logic             hit;
		logic [63:0]      pr;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		hit = 1'b0;
		for (int i = 0; i < MAX_RANGES; i++) begin
			pr = c.range_pair[i >> 1];
			lo = ((i & 1) != 0) ? pr[47:32] : pr[15:0];
			hi = ((i & 1) != 0) ? pr[63:48] : pr[31:16];
			if ((3'(i) < cnt) && (pos >= lo) && (pos <= hi)) begin
				hit = 1'b1;
			end
		end
		return c.option_flags[OPT_COMPLEMENT] ? !hit : hit;
	endfunction

	// Line state
	logic [POS_W-1:0] lp_q;
	logic [POS_W-1:0] fn_q;
	logic             ds_q;
	logic             ae_q;
	logic             zs_q;
	logic [LW-1:0]    len_q;

	logic [POS_W-1:0] lp_n;
	logic [POS_W-1:0] fn_n;
	logic             ds_n;
	logic             ae_n;
	logic             zs_n;
	logic [LW-1:0]    len_n;

	// Plan of the words for the byte being taken
	logic [LW-1:0] rel_n;
	logic          has_mid;
	logic          has_term;
	logic          mid_byte;
	logic [7:0]    mid_val;
	logic          wr_en;
	logic          do_close;
	logic          ae_tmp;
	logic [7:0]    total;

	logic [LW-1:0] rel_n_q;
	logic          has_mid_q;
	logic          has_term_q;
	logic [7:0]    mid_q;
	logic [7:0]    term_q;
	logic [LW-1:0] idx_q;

	// First-field store
	logic [7:0]    ff_mem_q [FIRST_FIELD_DEPTH];
	logic [7:0]    rd_q;
	logic [LW-1:0] rd_idx;
	logic [AW-1:0] rd_addr;

	logic [7:0]       out_byte_q;
	logic             run_last_q;
	logic             out_valid_q;

	logic [7:0]       term_b;
	logic [7:0]       sep_b;
	logic [2:0]       cnt;
	logic             fmode;
	logic             is_term;
	logic             is_delim;
	logic             lp_ok;
	logic [POS_W-1:0] lp_inc;
	logic [POS_W-1:0] fn_inc;
	logic [POS_W-1:0] pos;
	logic             sel_p;
	logic             sel_one;
	logic             store_ok;
	logic [7:0]       src_byte;

	// Decode the current byte against the configuration
	always_comb begin
		term_b   = cfg.option_flags[OPT_ZERO_TERM] ? ZERO_BYTE : NEWLINE_BYTE;
		sep_b    = cfg.option_flags[OPT_OUT_DELIM] ? cfg.output_delimiter
		                                           : cfg.field_delimiter;
		cnt      = (cfg.range_count > 3'(RANGE_SLOTS)) ? 3'(RANGE_SLOTS) : cfg.range_count;
		fmode    = cfg.select_mode;
		is_term  = (in_byte == term_b);
		is_delim = fmode && (in_byte == cfg.field_delimiter);
		lp_ok    = (lp_q < POS_W'(LINE_LIMIT));
		lp_inc   = lp_q + 1'b1;
		fn_inc   = (fn_q == {POS_W{1'b1}}) ? fn_q : fn_q + 1'b1;
		pos      = !fmode ? lp_inc : (is_delim ? fn_inc : fn_q);
		sel_p    = range_select(cfg, cnt, pos);
		sel_one  = range_select(cfg, cnt, POS_W'(1));
		store_ok = (len_q < LW'(FIRST_FIELD_DEPTH));
	end

	// Work out the next line state and the words this byte causes
	always_comb begin
		lp_n     = lp_q;
		fn_n     = fn_q;
		ds_n     = ds_q;
		ae_n     = ae_q;
		zs_n     = zs_q;
		len_n    = len_q;
		rel_n    = '0;
		has_mid  = 1'b0;
		has_term = 1'b0;
		mid_byte = 1'b1;
		wr_en    = 1'b0;
		do_close = 1'b0;
		ae_tmp   = ae_q;
		if (is_term) begin
			do_close = 1'b1;
		end else if (lp_ok) begin
			lp_n = lp_inc;
			if (!zs_q) begin
				if (in_byte == ZERO_BYTE) begin
					zs_n = 1'b1;
				end else if (!fmode) begin
					has_mid = sel_p;
				end else if (is_delim) begin
					ds_n = 1'b1;
					if (!ds_q && sel_one) begin
						rel_n  = len_q;
						ae_tmp = 1'b1;
					end
					fn_n = fn_inc;
					if (sel_p) begin
						has_mid  = ae_tmp;
						mid_byte = 1'b0;
						ae_tmp   = 1'b1;
					end
					ae_n = ae_tmp;
				end else if (!ds_q) begin
					if (store_ok) begin
						wr_en = 1'b1;
						len_n = len_q + 1'b1;
					end
				end else begin
					has_mid = sel_p;
				end
			end
		end
		if (!is_term && end_of_input && (lp_n != '0)) begin
			do_close = 1'b1;
		end
		// Close line: flush an undelimited first field and terminate, or drop both
		if (do_close) begin
			if (fmode && !ds_n) begin
				if (!cfg.option_flags[OPT_ONLY_DELIM]) begin
					rel_n    = len_n;
					has_term = 1'b1;
				end
			end else begin
				has_term = 1'b1;
			end
			lp_n  = '0;
			fn_n  = POS_W'(1);
			ds_n  = 1'b0;
			ae_n  = 1'b0;
			zs_n  = 1'b0;
			len_n = '0;
		end
		// Drop the terminator when the word count runs past the cap
		total = 8'(rel_n) + 8'(has_mid) + 8'(has_term);
		if (total > 8'(MAX_RESULTS)) begin
			has_term = 1'b0;
		end
		mid_val = mid_byte ? in_byte : sep_b;
	end

	// Advance line state on each taken byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			fn_q  <= POS_W'(1);
			ds_q  <= 1'b0;
			ae_q  <= 1'b0;
			zs_q  <= 1'b0;
			len_q <= '0;
		end else if (cmd.take) begin
			lp_q  <= lp_n;
			fn_q  <= fn_n;
			ds_q  <= ds_n;
			ae_q  <= ae_n;
			zs_q  <= zs_n;
			len_q <= len_n;
		end
	end

	// Capture the plan and step through the released field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_mid_q  <= 1'b0;
			has_term_q <= 1'b0;
			rel_n_q    <= '0;
			idx_q      <= '0;
		end else begin
			if (cmd.take) begin
				has_mid_q  <= has_mid;
				has_term_q <= has_term;
				rel_n_q    <= rel_n;
				idx_q      <= '0;
			end else if (cmd.advance) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mid_q  <= mid_val;
			term_q <= term_b;
		end
	end

	// Prefetch the next stored byte; release runs a word per cycle unless stalled
	always_comb begin
		rd_idx  = cmd.advance ? idx_q + 1'b1 : idx_q;
		rd_addr = (rd_idx < LW'(FIRST_FIELD_DEPTH)) ? rd_idx[AW-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.take && wr_en) begin
			ff_mem_q[len_q[AW-1:0]] <= in_byte;
		end
		rd_q <= ff_mem_q[rd_addr];
	end

	// Select the word for the output register
	always_comb begin
		case (cmd.src)
			SRC_REL:  src_byte = rd_q;
			SRC_MID:  src_byte = cmd.take ? mid_val : mid_q;
			SRC_TERM: src_byte = cmd.take ? term_b : term_q;
			default:  src_byte = rd_q;
		endcase
	end

	// Output register: load a word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= src_byte;
			run_last_q <= cmd.last;
		end
	end

	// Status to the controller
	always_comb begin
		stat.slot_free = !out_valid_q || out_ready;
		stat.plan_rel  = (rel_n != '0);
		stat.plan_mid  = has_mid;
		stat.plan_term = has_term;
		stat.q_mid     = has_mid_q;
		stat.q_term    = has_term_q;
		stat.rel_last  = (LW'(idx_q + 1'b1) == rel_n_q);
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

@@ rtl/delimited_field_byte_selector_core.sv @@
// Delimited field byte selector: a line filter that passes chosen byte
// positions or chosen delimited fields of a text stream.
//
// Channels: the input takes one text word (in_byte, end_of_input) per
// in_valid/in_ready handshake; the output gives one word (out_byte,
// run_last) per out_valid/out_ready handshake, run_last marking the final
// word caused by an input word. Configuration is a plain write port
// (cfg_write, cfg_index, cfg_data); the user must write it only while the
// block is idle. The block itself does not enforce this.
// Sequencing: an input word that causes no word or one word is finished
// on acceptance if the output register is free; one that causes a middle
// word and a terminator also passes the terminator state. A word that
// releases the buffered first field passes the prefetch state, where the
// first-field memory is read, then gives one byte a cycle while the output
// register is free; with no release, the first word loads on acceptance.
//
// Reset clears the line state, the controller and the output valid flag;
// configuration registers return to their reset values. When the receiver
// stalls, the output register holds its word and the block stops taking
// input once the word sequence of the current input word cannot advance.
`default_nettype none

module delimited_field_byte_selector_core
	import dfbs_pkg::*;
#(
	parameter int LINE_LIMIT        = DFBS_LINE_LIMIT,
	parameter int FIRST_FIELD_DEPTH = DFBS_FIRST_FIELD_DEPTH,
	parameter int RANGE_SLOTS       = DFBS_RANGE_SLOTS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  end_of_input,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [7:0]                 out_byte,
	output logic                       run_last
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	dfbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dfbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dfbs_dp #(
		.LINE_LIMIT        (LINE_LIMIT),
		.FIRST_FIELD_DEPTH (FIRST_FIELD_DEPTH),
		.RANGE_SLOTS       (RANGE_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.run_last     (run_last)
	);

endmodule

`default_nettype wire

@@ rtl/dfbs_sva.sv @@
// Port-level checks of the delimited field byte selector and their binding.
// Sees only the top-level ports; uses dfbs_pkg for widths.
`default_nettype none

module dfbs_sva
	import dfbs_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  cfg_write,
	input wire logic [CFG_IDX_W-1:0]  cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire logic [7:0]            in_byte,
	input wire logic                  end_of_input,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [7:0]            out_byte,
	input wire logic                  run_last
);

	// No word is offered while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output word offered during reset");

	// A stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("stalled output word changed");

	// While a word sequence is unfinished, no new input word is taken
	a_seq_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken with a word sequence pending");

	// A new output word follows an input take or ongoing sequence work
	a_no_spurious_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready || in_valid))
		else $error("output word without a cause");

endmodule

bind delimited_field_byte_selector_core dfbs_sva u_sva (.*);

`default_nettype wire
